// ----- rtl/i2c_master_write_read_top_defines.svh -----
// Assertion macros used by the port-level checker file.
`ifndef I2C_MASTER_WRITE_READ_TOP_DEFINES_SVH
`define I2C_MASTER_WRITE_READ_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define I2CMWR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2CMWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i2cmwr_pkg.sv -----
// Shared types, request codes and bus timing tables of the I2C master.
package i2cmwr_pkg;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_BEGIN = 2'd1;
    localparam logic [1:0] REQ_PUSH  = 2'd2;

    localparam logic [7:0] ADDR_RW_MASK  = 8'hfe;
    localparam logic [7:0] TEN_BIT_MASK  = 8'hf8;
    localparam logic [7:0] TEN_BIT_CODE  = 8'hf0;

    localparam int STEPS_PER_TICK = 4;

    typedef struct packed {
        logic [3:0] idle_gap;
        logic [3:0] hold_start;
        logic [3:0] low_time;
        logic [3:0] high_time;
        logic [3:0] setup_start;
        logic [3:0] setup_data;
        logic [3:0] rise;
        logic [3:0] fall;
        logic [3:0] setup_stop;
        logic [3:0] to_start;
        logic [3:0] to_byte;
        logic [3:0] to_bit;
        logic [3:0] to_ackstart;
        logic [3:0] to_ack;
    } t_timing;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_q_ctl;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic       last_slot;
        logic [7:0] head;
    } t_q_stat;

    function automatic t_timing f_timing(input logic fast);
        t_timing t;
        case (fast)
            1'b1: begin
                t = '{4'd2, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
                      4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2};
            end
            default: begin
                t = '{4'd5, 4'd4, 4'd5, 4'd4, 4'd5, 4'd2, 4'd2,
                      4'd2, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5};
            end
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/i2cmwr_queue.sv -----
// Write byte queue with a registered head byte.
module i2cmwr_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cmwr_pkg::t_q_ctl   i_ctl,
    output i2cmwr_pkg::t_q_stat  o_stat
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = ((AW > LW) ? AW : LW) + 1;

    logic [7:0]    r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [LW-1:0] r_level;
    logic [LW-1:0] n_level;
    logic [7:0]    r_head_byte;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;

    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_level);
        if (tail_sum >= SW'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SW'(QUEUE_DEPTH);
        end
        tail = tail_sum[AW-1:0];
        n_head = r_head;
        if (i_ctl.pop) begin
            n_head = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
        end
        n_level = r_level;
        if (i_ctl.push) begin
            n_level = r_level + LW'(1);
        end else if (i_ctl.pop) begin
            n_level = r_level - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[tail] <= i_ctl.data;
        end
        r_head_byte <= (i_ctl.push && tail == n_head) ? i_ctl.data : r_mem[n_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_level <= '0;
        end else begin
            r_head  <= n_head;
            r_level <= n_level;
        end
    end

    assign o_stat.empty     = (r_level == '0);
    assign o_stat.full      = (r_level == LW'(QUEUE_DEPTH));
    assign o_stat.last_slot = (r_level == LW'(QUEUE_DEPTH - 1));
    assign o_stat.head      = r_head_byte;

endmodule

// ----- rtl/i2c_master_write_read_top.sv -----
// Top level of the I2C master that runs a combined write-then-read transaction.
// Input channel: one request per transfer: a microsecond tick carrying the
// sampled clock and data lines, a begin request with address and byte counts,
// or a push of one write byte into the queue. Output channel: one result per
// accepted request with the line drives, a completed read byte, queue room,
// busy, done, status and a reject flag.
// The result of a request is registered at the edge that accepts it. The block
// takes one request per cycle while the receiver does not stall; the bus sequencer
// settles up to four phase steps of one tick within that request.
// Bus timing follows the standard or fast table set by the speed register; the
// user writes it through i_cfg_we / i_cfg_wdata while the block is idle; unchecked.
// Reset puts the sequencer in idle, both lines released, the queue empty and
// the standard table selected.
// While the receiver stalls, the result register holds its transfer and a new
// request is taken only in the cycle the held result is drained.
module i2c_master_write_read_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_slave_address,
    input  logic [7:0]  i_write_count,
    input  logic [7:0]  i_read_count,
    input  logic [7:0]  i_write_byte,
    input  logic        i_scl_in,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic [7:0]  o_read_data,
    output logic        o_read_valid,
    output logic        o_queue_room,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_status,
    output logic        o_rejected
);
    localparam int CW = (COUNT_BITS < 8) ? COUNT_BITS : 8;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAITCLK, PH_FETCH,
        PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D, PH_ST_E,
        PH_SB_A, PH_SB_B, PH_SB_C, PH_SB_D, PH_SB_E,
        PH_SA_A, PH_SA_B, PH_SA_S, PH_SA_E, PH_SA_F,
        PH_RX_NEXT, PH_RX_A, PH_RX_B, PH_RX_C, PH_RX_D,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D, PH_SP_E
    } t_phase;

    typedef enum logic [3:0] {
        SG_START1, SG_ADDRW1, SG_ADDRW2, SG_WRITE, SG_START2,
        SG_ADDRR1, SG_ADDRR2, SG_READ, SG_STOP
    } t_stage;

    typedef struct packed {
        t_phase        phase;
        t_stage        stage;
        t_phase        resume;
        logic [2:0]    bit_idx;
        logic [7:0]    shift;
        logic [3:0]    delay;
        logic [3:0]    wcnt;
        logic [3:0]    wait_limit;
        logic [3:0]    bit_limit;
        logic          tx;
        logic          scl;
        logic          sda;
        logic [CW-1:0] writes;
        logic [CW-1:0] reads;
        logic [15:0]   addr;
        logic          err;
    } t_eng;

    typedef struct packed {
        logic       halt;
        logic       pop;
        logic       rvalid;
        logic [7:0] rdata;
        logic       done;
        logic       status;
    } t_evt;

    typedef struct packed {
        t_eng e;
        t_evt v;
    } t_ctx;

    function automatic t_ctx f_pause(input t_ctx c, input logic [3:0] d, input t_phase nx);
        t_ctx r;
        r = c;
        r.e.delay = d;
        r.e.phase = nx;
        return r;
    endfunction

    function automatic t_ctx f_await(input t_ctx c, input i2cmwr_pkg::t_timing t,
                                     input logic [3:0] lim, input t_phase nx);
        t_ctx r;
        r = c;
        r.e.delay      = t.rise;
        r.e.wcnt       = '0;
        r.e.wait_limit = lim;
        r.e.resume     = nx;
        r.e.phase      = PH_WAITCLK;
        return r;
    endfunction

    function automatic t_ctx f_finish(input t_ctx c, input logic st);
        t_ctx r;
        r = c;
        r.e.phase    = PH_IDLE;
        r.e.delay    = '0;
        r.e.scl      = 1'b1;
        r.e.sda      = 1'b1;
        r.v.done     = 1'b1;
        r.v.status   = st;
        return r;
    endfunction

    function automatic t_ctx f_fail(input t_ctx c);
        t_ctx r;
        r = c;
        if (c.e.stage == SG_START1 || c.e.stage == SG_START2 || c.e.stage == SG_STOP) begin
            r = f_finish(c, 1'b1);
        end else begin
            r.e.err   = 1'b1;
            r.e.stage = SG_STOP;
            r.e.phase = PH_SP_A;
        end
        return r;
    endfunction

    function automatic t_ctx f_start_byte(input t_ctx c, input i2cmwr_pkg::t_timing t,
                                          input logic [7:0] val, input t_stage st);
        t_ctx r;
        r = c;
        r.e.stage     = st;
        r.e.shift     = val;
        r.e.bit_idx   = 3'd7;
        r.e.tx        = val[7];
        r.e.bit_limit = t.to_byte;
        r.e.phase     = PH_SB_A;
        return r;
    endfunction

    function automatic t_ctx f_step(input t_ctx c, input i2cmwr_pkg::t_timing t,
                                    input logic scl, input logic sda,
                                    input i2cmwr_pkg::t_q_stat q);
        t_ctx       r;
        logic [7:0] prod;
        logic       single;
        logic [3:0] low_sum;
        logic [2:0] nb;
        r       = c;
        prod    = {4'd0, c.e.wcnt} * {4'd0, t.rise};
        low_sum = t.fall + t.low_time;
        nb      = c.e.bit_idx - 3'd1;
        single  = (c.e.addr[7:0] != 8'd0) &&
                  ((c.e.addr[7:0] & i2cmwr_pkg::TEN_BIT_MASK) != i2cmwr_pkg::TEN_BIT_CODE);
        case (c.e.phase)
            PH_WAITCLK: begin
                if (scl) begin
                    r.e.wcnt  = '0;
                    r.e.phase = c.e.resume;
                end else if (prod > {4'd0, c.e.wait_limit}) begin
                    r = f_fail(c);
                end else begin
                    if (c.e.wcnt != 4'd15) r.e.wcnt = c.e.wcnt + 4'd1;
                    r.e.delay = t.rise;
                    if (t.rise == 4'd0) r.v.halt = 1'b1;
                end
            end
            PH_FETCH: begin
                if (c.e.writes == '0) begin
                    r.e.stage = SG_START2;
                    r.e.phase = PH_ST_A;
                end else if (q.empty) begin
                    r.v.halt = 1'b1;
                end else begin
                    r.v.pop    = 1'b1;
                    r.e.writes = c.e.writes - CW'(1);
                    r = f_start_byte(r, t, q.head, SG_WRITE);
                end
            end
            PH_ST_A: begin
                r.e.scl = 1'b1;
                r.e.sda = 1'b1;
                r = f_await(r, t, t.to_start, PH_ST_B);
            end
            PH_ST_B: r = f_pause(c, t.setup_start, PH_ST_C);
            PH_ST_C: begin
                r.e.scl = 1'b1;
                r.e.sda = 1'b0;
                r = f_pause(r, t.hold_start, PH_ST_D);
            end
            PH_ST_D: begin
                r.e.scl = 1'b0;
                r.e.sda = 1'b0;
                r = f_pause(r, t.fall, PH_ST_E);
            end
            PH_ST_E: begin
                if (c.e.stage == SG_START1) begin
                    r = f_start_byte(c, t, c.e.addr[7:0] & i2cmwr_pkg::ADDR_RW_MASK, SG_ADDRW1);
                end else begin
                    r = f_start_byte(c, t, (c.e.addr[7:0] & i2cmwr_pkg::ADDR_RW_MASK) | 8'd1,
                                     SG_ADDRR1);
                end
            end
            PH_SB_A: begin
                r.e.scl = 1'b0;
                r.e.sda = c.e.tx;
                r = f_pause(r, t.setup_data, PH_SB_B);
            end
            PH_SB_B: begin
                r.e.scl = 1'b1;
                r.e.sda = c.e.tx;
                r = f_await(r, t, c.e.bit_limit, PH_SB_C);
            end
            PH_SB_C: r = f_pause(c, t.high_time, PH_SB_D);
            PH_SB_D: begin
                r.e.scl = 1'b0;
                r.e.sda = c.e.tx;
                r = f_pause(r, low_sum, PH_SB_E);
            end
            PH_SB_E: begin
                if (c.e.stage == SG_READ) begin
                    if (c.e.reads != '0) r.e.reads = c.e.reads - CW'(1);
                    r.e.phase = PH_RX_NEXT;
                end else if (c.e.bit_idx == 3'd0) begin
                    r.e.phase = PH_SA_A;
                end else begin
                    r.e.bit_idx   = nb;
                    r.e.tx        = c.e.shift[nb];
                    r.e.bit_limit = (nb == 3'd7) ? t.to_byte : t.to_bit;
                    r.e.phase     = PH_SB_A;
                end
            end
            PH_SA_A: begin
                r.e.scl = 1'b0;
                r.e.sda = 1'b1;
                r = f_pause(r, t.setup_data, PH_SA_B);
            end
            PH_SA_B: begin
                r.e.scl = 1'b1;
                r.e.sda = 1'b1;
                r = f_await(r, t, t.to_ackstart, PH_SA_S);
            end
            PH_SA_S: begin
                if (!sda) begin
                    r = f_pause(c, t.high_time, PH_SA_E);
                end else if (prod > {4'd0, t.to_ack}) begin
                    r = f_fail(c);
                end else begin
                    if (c.e.wcnt != 4'd15) r.e.wcnt = c.e.wcnt + 4'd1;
                    r.e.delay = t.rise;
                    if (t.rise == 4'd0) r.v.halt = 1'b1;
                end
            end
            PH_SA_E: begin
                r.e.scl = 1'b0;
                r.e.sda = 1'b1;
                r = f_pause(r, low_sum, PH_SA_F);
            end
            PH_SA_F: begin
                case (c.e.stage)
                    SG_ADDRW1: begin
                        if (single) begin
                            r.e.stage = SG_WRITE;
                            r.e.phase = PH_FETCH;
                        end else begin
                            r = f_start_byte(c, t, c.e.addr[15:8], SG_ADDRW2);
                        end
                    end
                    SG_ADDRR1: begin
                        if (single) begin
                            r.e.stage = SG_READ;
                            r.e.phase = PH_RX_NEXT;
                        end else begin
                            r = f_start_byte(c, t, c.e.addr[15:8], SG_ADDRR2);
                        end
                    end
                    SG_ADDRW2, SG_WRITE: begin
                        r.e.stage = SG_WRITE;
                        r.e.phase = PH_FETCH;
                    end
                    SG_ADDRR2: begin
                        r.e.stage = SG_READ;
                        r.e.phase = PH_RX_NEXT;
                    end
                    default: begin
                        r.e.stage = SG_STOP;
                        r.e.phase = PH_SP_A;
                    end
                endcase
            end
            PH_RX_NEXT: begin
                if (c.e.reads == '0) begin
                    r.e.stage = SG_STOP;
                    r.e.phase = PH_SP_A;
                end else begin
                    r.e.scl     = 1'b0;
                    r.e.sda     = 1'b1;
                    r.e.shift   = '0;
                    r.e.bit_idx = 3'd7;
                    r.e.phase   = PH_RX_A;
                end
            end
            PH_RX_A: begin
                r.e.scl = 1'b1;
                r.e.sda = 1'b1;
                r = f_await(r, t, (c.e.bit_idx == 3'd7) ? t.to_byte : t.to_bit, PH_RX_B);
            end
            PH_RX_B: begin
                r.e.shift = {c.e.shift[6:0], sda};
                r = f_pause(r, t.high_time, PH_RX_C);
            end
            PH_RX_C: begin
                r.e.scl = 1'b0;
                r.e.sda = 1'b1;
                r = f_pause(r, low_sum, PH_RX_D);
            end
            PH_RX_D: begin
                if (c.e.bit_idx == 3'd0) begin
                    r.v.rvalid    = 1'b1;
                    r.v.rdata     = c.e.shift;
                    r.e.tx        = (c.e.reads > CW'(1)) ? 1'b0 : 1'b1;
                    r.e.bit_limit = t.to_bit;
                    r.e.phase     = PH_SB_A;
                end else begin
                    r.e.bit_idx = nb;
                    r.e.phase   = PH_RX_A;
                end
            end
            PH_SP_A: begin
                r.e.scl = 1'b0;
                r.e.sda = 1'b0;
                r = f_pause(r, t.rise, PH_SP_B);
            end
            PH_SP_B: begin
                r.e.scl = 1'b1;
                r.e.sda = 1'b0;
                r = f_await(r, t, t.to_ack, PH_SP_C);
            end
            PH_SP_C: r = f_pause(c, t.setup_stop, PH_SP_D);
            PH_SP_D: begin
                r.e.scl = 1'b1;
                r.e.sda = 1'b1;
                r = f_pause(r, t.idle_gap, PH_SP_E);
            end
            PH_SP_E: r = f_finish(c, c.e.err);
            default: begin
                r.e.phase = PH_IDLE;
                r.v.halt  = 1'b1;
            end
        endcase
        return r;
    endfunction

    t_eng                r_eng;
    logic                r_speed;
    logic                r_out_valid;
    logic                r_scl;
    logic                r_sda;
    logic [7:0]          r_rdata;
    logic                r_rvalid;
    logic                r_room;
    logic                r_busy;
    logic                r_done;
    logic                r_status;
    logic                r_rej;
    t_ctx                n_ctx;
    logic                n_rej;
    logic                n_room;
    logic                accept;
    i2cmwr_pkg::t_timing tm;
    i2cmwr_pkg::t_q_ctl  q_ctl;
    i2cmwr_pkg::t_q_stat q_stat;

    i2cmwr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .o_stat  (q_stat)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign tm         = i2cmwr_pkg::f_timing(r_speed);

    always_comb begin
        n_ctx   = '{e: r_eng, v: '0};
        n_rej   = 1'b0;
        q_ctl   = '{push: 1'b0, pop: 1'b0, data: i_write_byte};
        case (i_req_type)
            i2cmwr_pkg::REQ_TICK: begin
                if (r_eng.delay != 4'd0) begin
                    n_ctx.e.delay = r_eng.delay - 4'd1;
                    if (n_ctx.e.delay != 4'd0) n_ctx.v.halt = 1'b1;
                end
                for (int i = 0; i < i2cmwr_pkg::STEPS_PER_TICK; i++) begin
                    if (!n_ctx.v.halt && n_ctx.e.delay == 4'd0) begin
                        n_ctx = f_step(n_ctx, tm, i_scl_in, i_sda_in, q_stat);
                    end
                end
                q_ctl.pop = accept && n_ctx.v.pop;
            end
            i2cmwr_pkg::REQ_BEGIN: begin
                if (r_eng.phase != PH_IDLE) begin
                    n_rej = 1'b1;
                end else begin
                    n_ctx.e.addr   = i_slave_address;
                    n_ctx.e.writes = i_write_count[CW-1:0];
                    n_ctx.e.reads  = i_read_count[CW-1:0];
                    n_ctx.e.err    = 1'b0;
                    n_ctx.e.delay  = '0;
                    n_ctx.e.stage  = SG_START1;
                    n_ctx.e.phase  = PH_ST_A;
                end
            end
            i2cmwr_pkg::REQ_PUSH: begin
                if (q_stat.full) begin
                    n_rej = 1'b1;
                end else begin
                    q_ctl.push = accept;
                end
            end
            default: ;
        endcase
        if (i_req_type == i2cmwr_pkg::REQ_PUSH && !q_stat.full) begin
            n_room = !q_stat.last_slot;
        end else if (n_ctx.v.pop) begin
            n_room = 1'b1;
        end else begin
            n_room = !q_stat.full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_eng         <= '{phase: PH_IDLE, stage: SG_START1, resume: PH_IDLE,
                               scl: 1'b1, sda: 1'b1, default: '0};
        end else begin
            if (i_cfg_we) begin
                r_speed <= i_cfg_wdata;
            end
            if (accept) begin
                r_eng       <= n_ctx.e;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scl    <= n_ctx.e.scl;
            r_sda    <= n_ctx.e.sda;
            r_rdata  <= n_ctx.v.rdata;
            r_rvalid <= n_ctx.v.rvalid;
            r_room   <= n_room;
            r_busy   <= (n_ctx.e.phase != PH_IDLE);
            r_done   <= n_ctx.v.done;
            r_status <= n_ctx.v.status;
            r_rej    <= n_rej;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_out    = r_scl;
    assign o_sda_out    = r_sda;
    assign o_read_data  = r_rdata;
    assign o_read_valid = r_rvalid;
    assign o_queue_room = r_room;
    assign o_busy_res   = r_busy;
    assign o_done_res   = r_done;
    assign o_status     = r_status;
    assign o_rejected   = r_rej;

endmodule

// ----- rtl/i2cmwr_chk.sv -----
// Port-level checker of the I2C master and its bind to the top level.
`include "i2c_master_write_read_top_defines.svh"

module i2cmwr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_scl_out,
    input logic       o_sda_out,
    input logic       o_read_valid,
    input logic [7:0] o_read_data,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic       o_status
);
    `I2CMWR_ASSERT_NEXT(a_hold_stalled, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_data) && $stable(o_done_res), "stalled transfer changed")
    `I2CMWR_ASSERT_NOW(a_done_not_busy, o_out_valid && o_done_res, !o_busy_res && o_scl_out && o_sda_out, "done while busy or lines held")
    `I2CMWR_ASSERT_NOW(a_status_at_done, o_out_valid && o_status, o_done_res, "status without done")
    `I2CMWR_ASSERT_NOW(a_read_in_txn, o_out_valid && o_read_valid, o_busy_res && !o_done_res, "read byte outside transaction")
endmodule

bind i2c_master_write_read_top i2cmwr_chk u_i2cmwr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_scl_out    (o_scl_out),
    .o_sda_out    (o_sda_out),
    .o_read_valid (o_read_valid),
    .o_read_data  (o_read_data),
    .o_busy_res   (o_busy_res),
    .o_done_res   (o_done_res),
    .o_status     (o_status)
);

// ----- dv/i2c_master_write_read_checker.sv -----
// Checker: predicts every result of the I2C master and compares it with the block.
`timescale 1ns / 1ps
module i2c_master_write_read_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_slave_address,
    input  logic [7:0]  i_write_count,
    input  logic [7:0]  i_read_count,
    input  logic [7:0]  i_write_byte,
    input  logic        i_scl_in,
    input  logic        i_sda_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_scl_out,
    input  logic        i_sda_out,
    input  logic [7:0]  i_read_data,
    input  logic        i_read_valid,
    input  logic        i_queue_room,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic        i_status,
    input  logic        i_rejected,
    output int          o_errors,
    output int          o_pending,
    output int          o_bytes_read,
    output int          o_done_count
);

    localparam int QDEPTH = 16;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAITCLK, PH_FETCH,
        PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D, PH_ST_E,
        PH_SB_A, PH_SB_B, PH_SB_C, PH_SB_D, PH_SB_E,
        PH_SA_A, PH_SA_B, PH_SA_S, PH_SA_E, PH_SA_F,
        PH_RX_NEXT, PH_RX_A, PH_RX_B, PH_RX_C, PH_RX_D,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D, PH_SP_E
    } t_phase;

    typedef enum logic [3:0] {
        SG_START1, SG_ADDRW1, SG_ADDRW2, SG_WRITE, SG_START2,
        SG_ADDRR1, SG_ADDRR2, SG_READ, SG_STOP
    } t_stage;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rdata;
        logic       rvalid;
        logic       room;
        logic       busy;
        logic       done;
        logic       status;
        logic       rej;
    } t_bus_result;

    t_bus_result expected_results[$];

    logic       fast_mode;
    t_phase     phase, resume_phase;
    t_stage     stage;
    int         bit_index, shift_reg, delay_count, wait_count, wait_limit, bit_limit;
    int         writes_left, reads_left, queue_level, queue_head;
    logic [15:0] target_addr;
    logic       error_flag, tx_bit, scl_drv, sda_drv;
    logic [7:0] byte_queue [QDEPTH];
    logic       ev_valid, ev_done, ev_status;
    logic [7:0] ev_data;

    function automatic i2cmwr_pkg::t_timing bus_timing();
        i2cmwr_pkg::t_timing t;
        if (fast_mode) t = '{4'd2, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
                             4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2};
        else t = '{4'd5, 4'd4, 4'd5, 4'd4, 4'd5, 4'd2, 4'd2,
                   4'd2, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5};
        return t;
    endfunction

    function automatic void set_lines(logic c, logic d);
        scl_drv = c;
        sda_drv = d;
    endfunction

    function automatic void hold_for(int d, t_phase nxt);
        delay_count = d & 15;
        phase = nxt;
    endfunction

    function automatic void wait_clock(int limit, t_phase nxt);
        delay_count = bus_timing().rise;
        wait_count = 0;
        wait_limit = limit;
        resume_phase = nxt;
        phase = PH_WAITCLK;
    endfunction

    function automatic void end_transaction(logic st);
        phase = PH_IDLE;
        delay_count = 0;
        set_lines(1'b1, 1'b1);
        ev_done = 1'b1;
        ev_status = st;
    endfunction

    function automatic void go_stop();
        stage = SG_STOP;
        phase = PH_SP_A;
    endfunction

    function automatic void bus_fail();
        if (stage == SG_START1 || stage == SG_START2 || stage == SG_STOP) begin
            end_transaction(1'b1);
        end else begin
            error_flag = 1'b1;
            go_stop();
        end
    endfunction

    function automatic void next_bit();
        tx_bit = shift_reg[bit_index & 7];
        bit_limit = (bit_index == 7) ? bus_timing().to_byte : bus_timing().to_bit;
        phase = PH_SB_A;
    endfunction

    function automatic void load_tx_byte(logic [7:0] v, t_stage st);
        stage = st;
        shift_reg = v;
        bit_index = 7;
        next_bit();
    endfunction

    function automatic void ack_done();
        logic single;
        single = (target_addr[7:0] != 8'h00) &&
                 ((target_addr[7:0] & i2cmwr_pkg::TEN_BIT_MASK) != i2cmwr_pkg::TEN_BIT_CODE);
        case (stage)
            SG_ADDRW1: begin
                if (single) begin stage = SG_WRITE; phase = PH_FETCH; end
                else load_tx_byte(target_addr[15:8], SG_ADDRW2);
            end
            SG_ADDRR1: begin
                if (single) begin stage = SG_READ; phase = PH_RX_NEXT; end
                else load_tx_byte(target_addr[15:8], SG_ADDRR2);
            end
            SG_ADDRW2, SG_WRITE: begin
                stage = SG_WRITE;
                phase = PH_FETCH;
            end
            SG_ADDRR2: begin
                stage = SG_READ;
                phase = PH_RX_NEXT;
            end
            default: go_stop();
        endcase
    endfunction

    function automatic void bus_tick(logic scl, logic sda);
        i2cmwr_pkg::t_timing t;
        if (delay_count != 0) begin
            delay_count--;
            if (delay_count != 0) return;
        end
        for (int g = 0; g < 64; g++) begin
            if (delay_count != 0) return;
            t = bus_timing();
            case (phase)
                PH_WAITCLK: begin
                    if (scl) begin
                        wait_count = 0;
                        phase = resume_phase;
                    end else if (wait_count * t.rise > wait_limit) bus_fail();
                    else begin
                        if (wait_count < 15) wait_count++;
                        delay_count = t.rise;
                    end
                end
                PH_FETCH: begin
                    if (writes_left == 0) begin
                        stage = SG_START2;
                        phase = PH_ST_A;
                    end else if (queue_level == 0) return;
                    else begin
                        logic [7:0] v;
                        v = byte_queue[queue_head];
                        queue_head = (queue_head + 1) % QDEPTH;
                        queue_level--;
                        writes_left--;
                        load_tx_byte(v, SG_WRITE);
                    end
                end
                PH_ST_A: begin set_lines(1, 1); wait_clock(t.to_start, PH_ST_B); end
                PH_ST_B: hold_for(t.setup_start, PH_ST_C);
                PH_ST_C: begin set_lines(1, 0); hold_for(t.hold_start, PH_ST_D); end
                PH_ST_D: begin set_lines(0, 0); hold_for(t.fall, PH_ST_E); end
                PH_ST_E: begin
                    if (stage == SG_START1)
                        load_tx_byte(target_addr[7:0] & i2cmwr_pkg::ADDR_RW_MASK, SG_ADDRW1);
                    else
                        load_tx_byte((target_addr[7:0] & i2cmwr_pkg::ADDR_RW_MASK) | 8'h01,
                                     SG_ADDRR1);
                end
                PH_SB_A: begin set_lines(0, tx_bit); hold_for(t.setup_data, PH_SB_B); end
                PH_SB_B: begin set_lines(1, tx_bit); wait_clock(bit_limit, PH_SB_C); end
                PH_SB_C: hold_for(t.high_time, PH_SB_D);
                PH_SB_D: begin set_lines(0, tx_bit); hold_for(t.fall + t.low_time, PH_SB_E); end
                PH_SB_E: begin
                    if (stage == SG_READ) begin
                        if (reads_left != 0) reads_left--;
                        phase = PH_RX_NEXT;
                    end else if (bit_index == 0) phase = PH_SA_A;
                    else begin
                        bit_index--;
                        next_bit();
                    end
                end
                PH_SA_A: begin set_lines(0, 1); hold_for(t.setup_data, PH_SA_B); end
                PH_SA_B: begin set_lines(1, 1); wait_clock(t.to_ackstart, PH_SA_S); end
                PH_SA_S: begin
                    if (!sda) hold_for(t.high_time, PH_SA_E);
                    else if (wait_count * t.rise > t.to_ack) bus_fail();
                    else begin
                        if (wait_count < 15) wait_count++;
                        delay_count = t.rise;
                    end
                end
                PH_SA_E: begin set_lines(0, 1); hold_for(t.fall + t.low_time, PH_SA_F); end
                PH_SA_F: ack_done();
                PH_RX_NEXT: begin
                    if (reads_left == 0) go_stop();
                    else begin
                        set_lines(0, 1);
                        shift_reg = 0;
                        bit_index = 7;
                        phase = PH_RX_A;
                    end
                end
                PH_RX_A: begin
                    set_lines(1, 1);
                    wait_clock(bit_index == 7 ? t.to_byte : t.to_bit, PH_RX_B);
                end
                PH_RX_B: begin
                    shift_reg = ((shift_reg << 1) | sda) & 8'hff;
                    hold_for(t.high_time, PH_RX_C);
                end
                PH_RX_C: begin set_lines(0, 1); hold_for(t.fall + t.low_time, PH_RX_D); end
                PH_RX_D: begin
                    if (bit_index == 0) begin
                        ev_valid = 1'b1;
                        ev_data = shift_reg[7:0];
                        tx_bit = (reads_left > 1) ? 1'b0 : 1'b1;
                        bit_limit = t.to_bit;
                        phase = PH_SB_A;
                    end else begin
                        bit_index--;
                        phase = PH_RX_A;
                    end
                end
                PH_SP_A: begin set_lines(0, 0); hold_for(t.rise, PH_SP_B); end
                PH_SP_B: begin set_lines(1, 0); wait_clock(t.to_ack, PH_SP_C); end
                PH_SP_C: hold_for(t.setup_stop, PH_SP_D);
                PH_SP_D: begin set_lines(1, 1); hold_for(t.idle_gap, PH_SP_E); end
                PH_SP_E: end_transaction(error_flag);
                default: begin
                    phase = PH_IDLE;
                    return;
                end
            endcase
        end
    endfunction

    function automatic t_bus_result predict_request();
        t_bus_result r;
        logic rej;
        rej = 1'b0;
        ev_valid = 0; ev_data = 0; ev_done = 0; ev_status = 0;
        case (i_req_type)
            i2cmwr_pkg::REQ_TICK: bus_tick(i_scl_in, i_sda_in);
            i2cmwr_pkg::REQ_BEGIN: begin
                if (phase != PH_IDLE) rej = 1'b1;
                else begin
                    target_addr = i_slave_address;
                    writes_left = i_write_count;
                    reads_left = i_read_count;
                    error_flag = 1'b0;
                    delay_count = 0;
                    stage = SG_START1;
                    phase = PH_ST_A;
                end
            end
            i2cmwr_pkg::REQ_PUSH: begin
                if (queue_level >= QDEPTH) rej = 1'b1;
                else begin
                    byte_queue[(queue_head + queue_level) % QDEPTH] = i_write_byte;
                    queue_level++;
                end
            end
            default: ;
        endcase
        r.scl = scl_drv;
        r.sda = sda_drv;
        r.rdata = ev_valid ? ev_data : 8'h00;
        r.rvalid = ev_valid;
        r.room = queue_level < QDEPTH;
        r.busy = phase != PH_IDLE;
        r.done = ev_done;
        r.status = ev_done ? ev_status : 1'b0;
        r.rej = rej;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bus_result exp_r, got;
        if (!i_rst_n) begin
            fast_mode = 1'b0;
            phase = PH_IDLE;
            resume_phase = PH_IDLE;
            stage = SG_START1;
            bit_index = 0; shift_reg = 0; delay_count = 0; wait_count = 0;
            wait_limit = 0; bit_limit = 0; writes_left = 0; reads_left = 0;
            queue_level = 0; queue_head = 0; target_addr = '0;
            error_flag = 0; tx_bit = 0;
            set_lines(1'b1, 1'b1);
            expected_results.delete();
            o_errors = 0;
            o_bytes_read = 0;
            o_done_count = 0;
        end else begin
            if (i_cfg_we) fast_mode = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                got = '{i_scl_out, i_sda_out, i_read_data, i_read_valid, i_queue_room,
                        i_busy_res, i_done_res, i_status, i_rejected};
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result transfer %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.rvalid) o_bytes_read++;
                    if (got.done) o_done_count++;
                    if (got !== exp_r) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("mismatch scl/sda/data/rv/room/busy/done/st/rej");
                            $display("  exp %b %b %h %b %b %b %b %b %b",
                                     exp_r.scl, exp_r.sda, exp_r.rdata, exp_r.rvalid,
                                     exp_r.room, exp_r.busy, exp_r.done, exp_r.status,
                                     exp_r.rej);
                            $display("  got %b %b %h %b %b %b %b %b %b",
                                     got.scl, got.sda, got.rdata, got.rvalid, got.room,
                                     got.busy, got.done, got.status, got.rej);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_results.push_back(predict_request());
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- dv/i2c_master_write_read_top_tb.sv -----
// Testbench top: drives requests and configuration of the I2C master and reports the verdict.
`timescale 1ns / 1ps
module i2c_master_write_read_top_tb;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we, i_cfg_wdata;
    logic        i_in_valid, o_in_stall;
    logic [1:0]  i_req_type;
    logic [15:0] i_slave_address;
    logic [7:0]  i_write_count, i_read_count, i_write_byte;
    logic        i_scl_in, i_sda_in;
    logic        o_out_valid, i_out_stall;
    logic        o_scl_out, o_sda_out;
    logic [7:0]  o_read_data;
    logic        o_read_valid, o_queue_room, o_busy_res, o_done_res, o_status, o_rejected;

    int errors, pending, bytes_read, done_count;
    int requests_sent, idle_cycles;
    logic last_busy;
    int clean_lines;

    i2c_master_write_read_top DUT (.*);

    i2c_master_write_read_checker bus_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_in_valid, .i_in_stall(o_in_stall),
        .i_req_type, .i_slave_address, .i_write_count, .i_read_count, .i_write_byte,
        .i_scl_in, .i_sda_in, .i_out_valid(o_out_valid), .i_out_stall,
        .i_scl_out(o_scl_out), .i_sda_out(o_sda_out), .i_read_data(o_read_data),
        .i_read_valid(o_read_valid), .i_queue_room(o_queue_room), .i_busy_res(o_busy_res),
        .i_done_res(o_done_res), .i_status(o_status), .i_rejected(o_rejected),
        .o_errors(errors), .o_pending(pending), .o_bytes_read(bytes_read),
        .o_done_count(done_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if ((requests_sent / 300) % 3 == 2) i_out_stall <= 1'b0;
            else i_out_stall <= (gap_len() != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) last_busy <= 1'b0;
        else if (o_out_valid && !i_out_stall) last_busy <= o_busy_res;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] req, logic [15:0] addr, logic [7:0] wc,
                                logic [7:0] rc, logic [7:0] wbyte, logic scl, logic sda);
        int g;
        g = ((requests_sent / 200) % 4 == 3) ? 0 : gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_req_type <= req;
        i_slave_address <= addr;
        i_write_count <= wc;
        i_read_count <= rc;
        i_write_byte <= wbyte;
        i_scl_in <= scl;
        i_sda_in <= sda;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic tick();
        logic scl, sda;
        if (clean_lines != 0) begin
            scl = ($urandom_range(0, 19) != 0);
            sda = ($urandom_range(0, 9) < 4);
        end else begin
            scl = 1'($urandom_range(0, 1));
            sda = 1'($urandom_range(0, 1));
        end
        send_request(i2cmwr_pkg::REQ_TICK, 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), scl, sda);
    endtask

    task automatic push(logic [7:0] b);
        send_request(i2cmwr_pkg::REQ_PUSH, 16'($urandom), 8'($urandom), 8'($urandom), b,
                     1'($urandom), 1'($urandom));
    endtask

    task automatic begin_txn(logic [15:0] addr, logic [7:0] wc, logic [7:0] rc);
        send_request(i2cmwr_pkg::REQ_BEGIN, addr, wc, rc, 8'($urandom),
                     1'($urandom), 1'($urandom));
    endtask

    task automatic run_ticks(int n);
        repeat (n) tick();
    endtask

    task automatic settle_and_set_speed(logic fast);
        int guard;
        guard = 0;
        clean_lines = 1;
        while (last_busy && guard < 20000) begin
            if (guard % 16 == 0) push(8'($urandom));
            else tick();
            guard++;
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || last_busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= fast;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [15:0] addr;
        int wc;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = i2cmwr_pkg::REQ_TICK;
        i_slave_address = '0;
        i_write_count = '0;
        i_read_count = '0;
        i_write_byte = '0;
        i_scl_in = 1'b1;
        i_sda_in = 1'b1;
        requests_sent = 0;
        clean_lines = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: plain, general call, ten-bit, empty counts, full queue, short read
        settle_and_set_speed(1'b1);
        push(8'h00);
        push(8'hff);
        begin_txn(16'h00a4, 8'd2, 8'd1);
        begin_txn(16'hffff, 8'hff, 8'hff);
        run_ticks(150);
        begin_txn(16'h5a00, 8'd0, 8'd2);
        run_ticks(150);
        push(8'h3c);
        begin_txn(16'ha5f6, 8'd1, 8'd0);
        run_ticks(150);
        send_request(REQ_UNKNOWN, 16'hffff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1);
        repeat (18) push(8'($urandom));
        settle_and_set_speed(1'b0);
        begin_txn(16'h0012, 8'd0, 8'd3);
        run_ticks(150);
        clean_lines = 0;
        begin_txn(16'h0034, 8'd0, 8'd1);
        run_ticks(100);

        for (int ph = 0; ph < 4; ph++) begin
            settle_and_set_speed(ph[0]);
            while (requests_sent < 900 + (ph + 1) * 250) begin
                clean_lines = ($urandom_range(0, 9) < 8);
                wc = $urandom_range(0, 3);
                repeat ($urandom_range(0, 4)) push(8'($urandom));
                case ($urandom_range(0, 3))
                    0: addr = {8'($urandom_range(0, 255)), 8'h00};
                    1: addr = {8'($urandom), 5'b11110, 3'($urandom)};
                    default: addr = 16'($urandom);
                endcase
                begin_txn(addr, 8'(wc), 8'($urandom_range(0, 3)));
                for (int k = $urandom_range(30, 300); k > 0; k--) begin
                    case ($urandom_range(0, 39))
                        0: push(8'($urandom));
                        1: begin_txn(16'($urandom), 8'($urandom), 8'($urandom));
                        2: send_request(REQ_UNKNOWN, 16'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom), 1'($urandom),
                                        1'($urandom));
                        default: tick();
                    endcase
                end
            end
        end
        settle_and_set_speed(1'b0);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d requests in both timing modes:", requests_sent);
        $display("%0d transactions finished, %0d bytes read.", done_count, bytes_read);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
